### hw/rtl/cau_pkg.sv
// cau_pkg: shared types, codes and constants of the complex arithmetic unit.
// No dependencies; imported by every module under hw/rtl.
package cau_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int DIV_STEPS     = 32;   // quotient bits, one per divider stage

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	// classified item handed from front to back through the queue
	typedef struct packed {
		action_t            action;
		logic               dz;      // divide with zero divisor
		logic signed [31:0] a_real;
		logic signed [31:0] a_imag;
		logic signed [31:0] b_real;
		logic signed [31:0] b_imag;
	} item_t;

	typedef struct packed {
		logic [31:0] res_real;
		logic [31:0] res_imag;
		logic        div_zero;
		logic        overflow;
	} result_t;

	typedef struct packed {
		logic [31:0] val;
		logic        ovf;
	} sat_t;

	// clamp a signed value to 32 bits
	function automatic sat_t sat_signed(input logic signed [65:0] v);
		sat_t r;
		r.ovf = 1'b0;
		if (v > 66'sh0_0000_0000_7FFF_FFFF) begin
			r.val = 32'h7FFF_FFFF;
			r.ovf = 1'b1;
		end else if (v < -66'sh0_0000_0000_8000_0000) begin
			r.val = 32'h8000_0000;
			r.ovf = 1'b1;
		end else begin
			r.val = v[31:0];
		end
		return r;
	endfunction

	// sign and magnitude to clamped two's complement
	function automatic sat_t sat_mag(input logic neg, input logic [33:0] mag);
		sat_t r;
		r.ovf = 1'b0;
		if (!neg) begin
			if (mag > 34'h0_7FFF_FFFF) begin
				r.val = 32'h7FFF_FFFF;
				r.ovf = 1'b1;
			end else begin
				r.val = mag[31:0];
			end
		end else begin
			if (mag > 34'h0_8000_0000) begin
				r.val = 32'h8000_0000;
				r.ovf = 1'b1;
			end else begin
				r.val = 32'(~mag[31:0] + 32'd1);
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/complex_arithmetic_unit.sv
// complex_arithmetic_unit: top level; front classifier, item queue, execution back end.
// Depends on cau_pkg, cau_front, cau_queue, cau_back.
//
// Complex add, subtract, multiply and divide on signed fixed-point operands
// (FRAC_BITS fraction bits, Q16.16 by default). Operands arrive on the slave
// stream, one pair per beat; the result leaves on the master stream, one beat
// per input beat, in order. The unit takes one beat per clock as long as the
// master side keeps taking results. An accepted input beat passes through
// the input queue, the register of products and plain sums, the register
// of combined sums, the saturation and divider setup register, 32 divider
// stages (one quotient bit each, two restoring dividers in parallel for the
// real and imaginary parts) and is finally offered as a result beat from
// the output register. Every action goes through the same pipeline, so
// ordering is kept for free. When the master stalls the whole back end
// holds, and the queue keeps absorbing input beats until it fills. Products
// round toward minus infinity, quotients truncate toward zero, each part
// saturates to 32 bits with the overflow flag raised; a divide by a zero
// divisor returns zero with div_zero set.
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // a_real, a_imag, b_real, b_imag
	input  logic [1:0]   s_tuser,   // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // res_real, res_imag
	output logic [1:0]   m_tuser    // div_zero, overflow
);
	import cau_pkg::*;

	item_t   fr_item, q_item;
	logic    fr_valid, fr_ready;
	logic    q_valid, q_ready;
	result_t res;

	// front: decode action, flag zero divisor
	cau_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item       (fr_item)
	);

	// queue decouples input acceptance from back-end stalls
	cau_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// back: arithmetic pipeline and output register
	cau_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.res_imag, res.res_real};
	assign m_tuser = {res.overflow, res.div_zero};

endmodule

### hw/rtl/cau_front.sv
// cau_front: accepts input beats and classifies them (action, zero divisor).
// Depends on cau_pkg.
module cau_front (
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [127:0]    s_tdata,
	input  logic [1:0]      s_tuser,
	output logic            item_valid,
	input  logic            item_ready,
	output cau_pkg::item_t  item
);
	import cau_pkg::*;

	logic b_zero;

	assign b_zero = (s_tdata[95:64] == 32'd0) && (s_tdata[127:96] == 32'd0);

	always_comb begin
		item.action = action_t'(s_tuser);
		item.a_real = s_tdata[31:0];
		item.a_imag = s_tdata[63:32];
		item.b_real = s_tdata[95:64];
		item.b_imag = s_tdata[127:96];
		item.dz     = (action_t'(s_tuser) == ACT_DIV) && b_zero;
	end

	assign item_valid = s_tvalid;
	assign s_tready   = item_ready;

endmodule

### hw/rtl/cau_queue.sv
// cau_queue: short FIFO of classified items between front and back.
// Depends on cau_pkg.
module cau_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  cau_pkg::item_t  push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output cau_pkg::item_t  pop_item
);
	import cau_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign push_ready = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/cau_back.sv
// cau_back: pipelined execution: products, sums, saturation and a
// one-bit-per-stage restoring divider, plus the output register. Depends on cau_pkg.
module cau_back #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cau_pkg::item_t    in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output cau_pkg::result_t  out_res
);
	import cau_pkg::*;

	localparam int NW = 64 + FRAC_BITS;

	typedef struct packed {
		logic        is_div;
		logic        dz;
		logic [31:0] res_re;
		logic [31:0] res_im;
		logic        ovf;
		logic        neg_re;
		logic        neg_im;
		logic        clamp_re;
		logic        clamp_im;
		logic [63:0] den;
		logic [63:0] r_re;
		logic [63:0] r_im;
		logic [31:0] n_re;
		logic [31:0] n_im;
		logic [31:0] q_re;
		logic [31:0] q_im;
	} dstage_t;

	logic adv;

	// stage 1: products and plain sums
	logic               v_s1;
	action_t            op_s1;
	logic               dz_s1;
	logic signed [63:0] ac_s1, bd_s1, ad_s1, bc_s1;
	logic [63:0]        cc_s1, dd_s1;
	logic signed [32:0] sr_s1, si_s1;
	logic [31:0]        mc, md;

	// stage 2: combined sums
	logic               v_s2;
	action_t            op_s2;
	logic               dz_s2;
	logic signed [64:0] re_s2, im_s2;
	logic [63:0]        den_s2;

	// divider stages, index 0 is stage 3
	logic    dv_s [DIV_STEPS+1];
	dstage_t ds_s [DIV_STEPS+1];
	dstage_t d0;

	logic    out_valid_q;
	result_t out_q;
	result_t fin;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	assign mc = in_item.b_real[31] ? 32'(~in_item.b_real + 32'sd1) : in_item.b_real;
	assign md = in_item.b_imag[31] ? 32'(~in_item.b_imag + 32'sd1) : in_item.b_imag;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= in_item.action;
			dz_s1 <= in_item.dz;
			ac_s1 <= in_item.a_real * in_item.b_real;
			bd_s1 <= in_item.a_imag * in_item.b_imag;
			ad_s1 <= in_item.a_real * in_item.b_imag;
			bc_s1 <= in_item.a_imag * in_item.b_real;
			cc_s1 <= mc * mc;
			dd_s1 <= md * md;
			if (in_item.action == ACT_SUB) begin
				sr_s1 <= 33'(in_item.a_real) - 33'(in_item.b_real);
				si_s1 <= 33'(in_item.a_imag) - 33'(in_item.b_imag);
			end else begin
				sr_s1 <= 33'(in_item.a_real) + 33'(in_item.b_real);
				si_s1 <= 33'(in_item.a_imag) + 33'(in_item.b_imag);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2  <= op_s1;
			dz_s2  <= dz_s1;
			den_s2 <= cc_s1 + dd_s1;
			case (op_s1)
				ACT_MUL: begin
					re_s2 <= 65'(ac_s1) - 65'(bd_s1);
					im_s2 <= 65'(ad_s1) + 65'(bc_s1);
				end
				ACT_DIV: begin
					re_s2 <= 65'(ac_s1) + 65'(bd_s1);
					im_s2 <= 65'(bc_s1) - 65'(ad_s1);
				end
				default: begin
					re_s2 <= 65'(sr_s1);
					im_s2 <= 65'(si_s1);
				end
			endcase
		end
	end

	// stage 3: saturate non-divide results, set up the divider
	always_comb begin
		logic signed [64:0] rs, is;
		logic [63:0]        mre, mim;
		logic [NW-1:0]      nre, nim;
		sat_t               sre, sim;
		if (op_s2 == ACT_MUL) begin
			rs = re_s2 >>> FRAC_BITS;
			is = im_s2 >>> FRAC_BITS;
		end else begin
			rs = re_s2;
			is = im_s2;
		end
		sre = sat_signed(66'(rs));
		sim = sat_signed(66'(is));
		mre = re_s2[64] ? 64'(-re_s2) : re_s2[63:0];
		mim = im_s2[64] ? 64'(-im_s2) : im_s2[63:0];
		nre = NW'(mre) << FRAC_BITS;
		nim = NW'(mim) << FRAC_BITS;
		d0.is_div   = (op_s2 == ACT_DIV);
		d0.dz       = dz_s2;
		d0.res_re   = sre.val;
		d0.res_im   = sim.val;
		d0.ovf      = sre.ovf | sim.ovf;
		d0.neg_re   = re_s2[64];
		d0.neg_im   = im_s2[64];
		d0.clamp_re = 96'(nre) >= {den_s2, 32'd0};
		d0.clamp_im = 96'(nim) >= {den_s2, 32'd0};
		d0.den      = den_s2;
		d0.r_re     = 64'(nre[NW-1:32]);
		d0.r_im     = 64'(nim[NW-1:32]);
		d0.n_re     = nre[31:0];
		d0.n_im     = nim[31:0];
		d0.q_re     = '0;
		d0.q_im     = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ds_s[0] <= d0;
		end
	end

	// one quotient bit per stage for each part
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [64:0] t_re, t_im;
		logic        ge_re, ge_im;
		dstage_t     nx;

		always_comb begin
			t_re  = {ds_s[k].r_re, ds_s[k].n_re[31]};
			t_im  = {ds_s[k].r_im, ds_s[k].n_im[31]};
			ge_re = t_re >= {1'b0, ds_s[k].den};
			ge_im = t_im >= {1'b0, ds_s[k].den};
			nx      = ds_s[k];
			nx.r_re = ge_re ? 64'(t_re - {1'b0, ds_s[k].den}) : t_re[63:0];
			nx.r_im = ge_im ? 64'(t_im - {1'b0, ds_s[k].den}) : t_im[63:0];
			nx.n_re = {ds_s[k].n_re[30:0], 1'b0};
			nx.n_im = {ds_s[k].n_im[30:0], 1'b0};
			nx.q_re = {ds_s[k].q_re[30:0], ge_re};
			nx.q_im = {ds_s[k].q_im[30:0], ge_im};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ds_s[k+1] <= nx;
			end
		end
	end

	// valid bits of stages 1, 2 and the divider chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i <= DIV_STEPS; i++) begin
				dv_s[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			dv_s[0] <= v_s2;
			for (int i = 0; i < DIV_STEPS; i++) begin
				dv_s[i+1] <= dv_s[i];
			end
		end
	end

	// final sign, clamp and result select
	always_comb begin
		dstage_t     l;
		logic [33:0] mre, mim;
		sat_t        sre, sim;
		l   = ds_s[DIV_STEPS];
		mre = l.clamp_re ? 34'h2_0000_0000 : 34'(l.q_re);
		mim = l.clamp_im ? 34'h2_0000_0000 : 34'(l.q_im);
		sre = sat_mag(l.neg_re && (mre != '0), mre);
		sim = sat_mag(l.neg_im && (mim != '0), mim);
		if (!l.is_div) begin
			fin.res_real = l.res_re;
			fin.res_imag = l.res_im;
			fin.div_zero = 1'b0;
			fin.overflow = l.ovf;
		end else if (l.dz) begin
			fin.res_real = '0;
			fin.res_imag = '0;
			fin.div_zero = 1'b1;
			fin.overflow = 1'b0;
		end else begin
			fin.res_real = sre.val;
			fin.res_imag = sim.val;
			fin.div_zero = 1'b0;
			fin.overflow = sre.ovf | sim.ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_s[DIV_STEPS];
		end
	end

endmodule

### tb/complex_arithmetic_unit_tb.sv
// complex_arithmetic_unit_tb: self-checking bench for the complex arithmetic unit.
// Depends on cau_pkg and complex_arithmetic_unit; drives random and directed beats,
// predicts each result in software and checks the output stream in order.
module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam int FB        = 16;
	localparam int N_RANDOM  = 1930;
	localparam int LAT       = 36;
	localparam longint LIMIT = 400000;

	typedef struct {
		action_t     action;
		logic [31:0] ar, ai, br, bi;
	} op_t;

	typedef struct {
		logic [31:0] re, im;
		logic        dz, ovf;
	} res_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;    // a_real, a_imag, b_real, b_imag
	logic [1:0]   s_tuser = '0;    // action
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;         // res_real, res_imag
	logic [1:0]   m_tuser;         // div_zero, overflow

	op_t    pending_ops[$];
	res_t   expected_results[$];
	int     errors = 0;
	int     checked = 0;
	int     op_count[4] = '{0, 0, 0, 0};
	int     ovf_seen = 0;
	int     dz_seen = 0;
	longint cycles = 0;
	int     send_gap = 0;
	int     recv_gap = 0;
	int     hold_off = 0;
	bit     hold_done = 1'b0;

	complex_arithmetic_unit #(.FRAC_BITS(FB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	// clamp a signed 130-bit value to 32 bits
	function automatic logic [31:0] clamp32(input logic signed [129:0] v, inout logic ovf);
		if (v > 130'sh7FFF_FFFF) begin
			ovf = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -130'sh8000_0000) begin
			ovf = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// truncated quotient of (num << FB) / den, signs handled on magnitudes
	function automatic logic signed [129:0] fix_quot(input logic signed [129:0] num,
			input logic signed [129:0] den);
		logic [129:0] mag;
		logic [129:0] q;
		mag = num < 0 ? -num : num;
		q = (mag << FB) / den;
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic res_t complex_result(input op_t op);
		res_t r;
		logic signed [129:0] a, b, c, d, s1, s2, den;
		a = $signed(op.ar); b = $signed(op.ai);
		c = $signed(op.br); d = $signed(op.bi);
		r = '{re: '0, im: '0, dz: 1'b0, ovf: 1'b0};
		case (op.action)
			ACT_ADD: begin
				r.re = clamp32(a + c, r.ovf);
				r.im = clamp32(b + d, r.ovf);
			end
			ACT_SUB: begin
				r.re = clamp32(a - c, r.ovf);
				r.im = clamp32(b - d, r.ovf);
			end
			ACT_MUL: begin
				s1 = a * c - b * d;
				s2 = a * d + b * c;
				r.re = clamp32(s1 >>> FB, r.ovf);
				r.im = clamp32(s2 >>> FB, r.ovf);
			end
			default: begin
				den = c * c + d * d;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					r.re = clamp32(fix_quot(a * c + b * d, den), r.ovf);
					r.im = clamp32(fix_quot(b * c - a * d, den), r.ovf);
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(0, 8)) - 4);
			3: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
			4: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
			5: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_op(input action_t act, input logic [31:0] ar, ai, br, bi);
		op_t op;
		op = '{action: act, ar: ar, ai: ai, br: br, bi: bi};
		pending_ops.push_back(op);
	endtask

	task automatic report(input string what, input res_t want, input res_t got);
		errors++;
		$display("mismatch %s: want re=%h im=%h dz=%b ovf=%b, got re=%h im=%h dz=%b ovf=%b",
			what, want.re, want.im, want.dz, want.ovf, got.re, got.im, got.dz, got.ovf);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: holds a beat until accepted, then moves on after a random gap
	always @(posedge clk) begin
		op_t op;
		int  gap;
		if (arst_n) begin
			gap = send_gap;
			if (s_tvalid && s_tready) begin
				expected_results.push_back(complex_result(pending_ops.pop_front()));
				gap = pick_gap();
			end
			if (s_tvalid && !s_tready) begin
				// keep offering
			end else if (gap > 0) begin
				if (!s_tvalid) gap = gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				op = pending_ops[0];
				s_tdata <= {op.bi, op.br, op.ai, op.ar};
				s_tuser <= op.action;
				op_count[op.action]++;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
			send_gap <= gap;
		end
	end

	// one long receiver hold-off once traffic is flowing
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && checked >= 400) begin
				hold_done <= 1'b1;
				hold_off <= 200;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
			end
		end
	end

	// monitor: random back-pressure; checks each beat
	always @(posedge clk) begin
		res_t got, want;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{re: m_tdata[31:0], im: m_tdata[63:32], dz: m_tuser[0], ovf: m_tuser[1]};
				if (expected_results.size() == 0) begin
					want = '{re: '0, im: '0, dz: 1'b0, ovf: 1'b0};
					report("unexpected beat", want, got);
				end else begin
					want = expected_results.pop_front();
					checked++;
					ovf_seen += got.ovf;
					dz_seen += got.dz;
					if (got.re !== want.re) report("res_real", want, got);
					if (got.im !== want.im) report("res_imag", want, got);
					if (got.dz !== want.dz) report("div_zero", want, got);
					if (got.ovf !== want.ovf) report("overflow", want, got);
				end
			end
			if (hold_off > 0) begin
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready) recv_gap <= pick_gap();
			end
		end
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("complex_arithmetic_unit_tb: errors");
			$finish;
		end
	end

	initial begin
		logic [31:0] ext[4];
		ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
		// directed: extremes per action, unit values, divide by zero, tiny divisors
		for (int act = 0; act < 4; act++) begin
			push_op(action_t'(act), ext[0], ext[0], ext[0], ext[0]);
			push_op(action_t'(act), ext[1], ext[1], ext[1], ext[1]);
			push_op(action_t'(act), ext[0], ext[1], ext[1], ext[0]);
			push_op(action_t'(act), 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000);
		end
		push_op(ACT_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
		push_op(ACT_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
		push_op(ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1);
		push_op(ACT_DIV, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h0);
		push_op(ACT_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0);
		push_op(ACT_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
		for (int i = 0; i < N_RANDOM; i++)
			push_op(action_t'($urandom_range(0, 3)), rand_part(), rand_part(),
				rand_part(), rand_part());
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_ops.size() == 0 && expected_results.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		$display("checked %0d results: add %0d, sub %0d, mul %0d, div %0d beats sent",
			checked, op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("saturated results %0d, zero-divisor results %0d", ovf_seen, dz_seen);
		if (errors == 0) begin
			$display("complex_arithmetic_unit_tb: clean");
		end else begin
			$display("complex_arithmetic_unit_tb: errors");
		end
		$finish;
	end

endmodule
